// File: rtl/u2c_pkg.sv
`timescale 1ns / 1ps
package u2c_pkg;

    localparam logic [7:0] QMARK    = 8'h3F;
    localparam logic [7:0] LEAD_C2  = 8'hC2;
    localparam logic [7:0] LEAD_D0  = 8'hD0;
    localparam logic [7:0] LEAD_D1  = 8'hD1;
    localparam logic [7:0] LEAD_D2  = 8'hD2;
    localparam logic [7:0] LEAD_E2  = 8'hE2;
    localparam int         QDEPTH   = 4;
    localparam int         QAW      = 2;

    // Class of a sequence: mapped to a row, bad, or needing more bytes
    typedef enum logic [1:0] {
        CLS_ROW  = 2'd0,
        CLS_BAD  = 2'd1,
        CLS_NEED = 2'd2
    } cls_t;

    typedef struct packed {
        cls_t       cls;
        logic [3:0] row;
    } cls_res_t;

    // Up to three result bytes of one input beat
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } grp_t;

    localparam logic [7:0] CYR_MAP [256] = '{
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h98,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'hA0,8'h00,8'h00,8'h00,8'hA4,8'h00,8'hA6,8'hA7,8'h00,8'hA9,8'h00,8'hAB,8'hAC,8'hAD,8'hAE,8'h00,
        8'hB0,8'hB1,8'h00,8'h00,8'h00,8'hB5,8'hB6,8'hB7,8'h00,8'h00,8'h00,8'hBB,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'hA8,8'h80,8'h81,8'hAA,8'hBD,8'hB2,8'hAF,8'hA3,8'h8A,8'h8C,8'h8E,8'h8D,8'h00,8'hA1,8'h8F,
        8'hC0,8'hC1,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hCA,8'hCB,8'hCC,8'hCD,8'hCE,8'hCF,
        8'hD0,8'hD1,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,8'hD7,8'hD8,8'hD9,8'hDA,8'hDB,8'hDC,8'hDD,8'hDE,8'hDF,
        8'hE0,8'hE1,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hEA,8'hEB,8'hEC,8'hED,8'hEE,8'hEF,
        8'hF0,8'hF1,8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'hFA,8'hFB,8'hFC,8'hFD,8'hFE,8'hFF,
        8'h00,8'hB8,8'h90,8'h83,8'hBA,8'hBE,8'hB3,8'hBF,8'hBC,8'h9A,8'h9C,8'h9E,8'h9D,8'h00,8'hA2,8'h9F,
        8'hA5,8'hB4,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h96,8'h97,8'h00,8'h00,8'h00,8'h91,8'h92,8'h82,8'h00,8'h93,8'h94,8'h84,8'h00,
        8'h86,8'h87,8'h95,8'h00,8'h00,8'h00,8'h85,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h89,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h8B,8'h9B,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h88,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hB9,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h99,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
    };

    function automatic logic is_lead(input logic [7:0] b);
        return b == LEAD_C2 || b == LEAD_D0 || b == LEAD_D1 || b == LEAD_D2 || b == LEAD_E2;
    endfunction

    // Classify a sequence of n bytes (1..3) at s0,s1,s2
    function automatic cls_res_t classify(input logic [7:0] s0, input logic [7:0] s1,
                                          input logic [7:0] s2, input logic [1:0] n);
        cls_res_t   r;
        logic [3:0] hi;
        logic [3:0] lo;
        logic [3:0] hi2;
        r.cls = CLS_BAD;
        r.row = 4'd0;
        hi  = s1[7:4];
        lo  = s1[3:0];
        hi2 = s2[7:4];
        if (n < 2'd2)
        begin
            r.cls = is_lead(s0) ? CLS_NEED : CLS_BAD;
        end
        else
        begin
            unique case (s0)
                LEAD_C2:
                    if (hi >= 4'd9 && hi <= 4'd11)
                    begin
                        r.cls = CLS_ROW;
                        r.row = hi - 4'd9;
                    end
                LEAD_D0:
                    if (hi >= 4'd8 && hi <= 4'd11)
                    begin
                        r.cls = CLS_ROW;
                        r.row = hi - 4'd5;
                    end
                LEAD_D1:
                    if (hi >= 4'd8 && hi <= 4'd9)
                    begin
                        r.cls = CLS_ROW;
                        r.row = hi - 4'd1;
                    end
                LEAD_D2:
                    if (hi == 4'd9)
                    begin
                        r.cls = CLS_ROW;
                        r.row = 4'd9;
                    end
                LEAD_E2:
                    if (hi == 4'd8 && (lo == 4'd0 || lo == 4'd2 || lo == 4'd4))
                    begin
                        if (n < 2'd3)
                            r.cls = CLS_NEED;
                        else if (lo == 4'd0 && hi2 >= 4'd9 && hi2 <= 4'd11)
                        begin
                            r.cls = CLS_ROW;
                            r.row = hi2 + 4'd1;
                        end
                        else if (lo == 4'd2 && hi2 == 4'd10)
                        begin
                            r.cls = CLS_ROW;
                            r.row = 4'd13;
                        end
                        else if (lo == 4'd4 && hi2 >= 4'd9 && hi2 <= 4'd10)
                        begin
                            r.cls = CLS_ROW;
                            r.row = hi2 + 4'd5;
                        end
                    end
                default: r.cls = CLS_BAD;
            endcase
        end
        return r;
    endfunction

    function automatic logic [7:0] map_byte(input logic [3:0] row, input logic [3:0] col);
        logic [7:0] v;
        v = CYR_MAP[{row, col}];
        return (v == 8'h00) ? QMARK : v;
    endfunction

endpackage

// File: rtl/u2c_front.sv
`timescale 1ns / 1ps
module u2c_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  logic [7:0]     in_byte,
    input  logic           end_of_stream,
    output u2c_pkg::grp_t  grp
);
    import u2c_pkg::*;

    logic [7:0] lead_reg, lead_next;
    logic [7:0] second_reg, second_next;
    logic [1:0] cnt_reg, cnt_next;

    // Decode the held bytes plus the new byte; at most three passes
    always_comb
    begin
        logic [7:0] buf_b [3];
        logic [1:0] n;
        logic [1:0] p;
        logic [1:0] oc;
        logic [7:0] ob [3];
        logic       stop;
        cls_res_t   r;
        logic [7:0] s1;
        logic [7:0] s2;
        logic [7:0] v;
        buf_b[0] = in_byte;
        buf_b[1] = in_byte;
        buf_b[2] = in_byte;
        n = 2'd1;
        if (cnt_reg == 2'd1)
        begin
            buf_b[0] = lead_reg;
            n = 2'd2;
        end
        else if (cnt_reg >= 2'd2)
        begin
            buf_b[0] = lead_reg;
            buf_b[1] = second_reg;
            n = 2'd3;
        end
        p = 2'd0;
        oc = 2'd0;
        ob[0] = QMARK;
        ob[1] = QMARK;
        ob[2] = QMARK;
        stop = 1'b0;
        lead_next = 8'h00;
        second_next = 8'h00;
        cnt_next = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            if (!stop && p < n)
            begin
                s1 = (p == 2'd0) ? buf_b[1] : buf_b[2];
                s2 = buf_b[2];
                v = QMARK;
                if (!buf_b[p][7])
                begin
                    v = buf_b[p];
                    p = p + 2'd1;
                end
                else
                begin
                    r = classify(buf_b[p], s1, s2, n - p);
                    priority case (r.cls)
                        CLS_NEED:
                        begin
                            cnt_next = n - p;
                            lead_next = buf_b[p];
                            second_next = s1;
                            stop = 1'b1;
                        end
                        CLS_ROW:
                        begin
                            if (buf_b[p] == LEAD_E2)
                            begin
                                v = map_byte(r.row, s2[3:0]);
                                p = p + 2'd3;
                            end
                            else
                            begin
                                v = map_byte(r.row, s1[3:0]);
                                p = p + 2'd2;
                            end
                        end
                        default: p = p + 2'd1;
                    endcase
                end
                if (!stop)
                begin
                    ob[oc] = v;
                    oc = oc + 2'd1;
                end
            end
        end
        // Flush held bytes as question marks
        if (end_of_stream)
        begin
            oc = oc + cnt_next;
            cnt_next = 2'd0;
            lead_next = 8'h00;
            second_next = 8'h00;
        end
        grp.cnt = oc;
        grp.b0 = ob[0];
        grp.b1 = ob[1];
        grp.b2 = ob[2];
    end

    // Hold the partial sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            lead_reg <= 8'h00;
            second_reg <= 8'h00;
        end
        else if (take)
        begin
            cnt_reg <= cnt_next;
            lead_reg <= lead_next;
            second_reg <= second_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("held count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        take && end_of_stream |=> cnt_reg == 2'd0)
        else $error("bytes held after end of stream");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd0 |-> lead_reg[7])
        else $error("held lead below 0x80");
endmodule

// File: rtl/u2c_back.sv
`timescale 1ns / 1ps
module u2c_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  u2c_pkg::grp_t  grp,
    output logic           q_full,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     out_byte,
    output logic           last_of_run
);
    import u2c_pkg::*;

    grp_t            q_reg [QDEPTH];
    logic [QAW-1:0]  wp_reg, rp_reg;
    logic [QAW:0]    cnt_reg;
    logic [1:0]      idx_reg;
    grp_t            head;
    logic            rd;
    logic            grp_done;

    assign head = q_reg[rp_reg];
    assign empty = (cnt_reg == '0);
    assign q_full = (cnt_reg == (QAW+1)'(QDEPTH));

    // Pick the current byte of the head group
    always_comb
    begin
        unique case (idx_reg)
            2'd0:    out_byte = head.b0;
            2'd1:    out_byte = head.b1;
            default: out_byte = head.b2;
        endcase
    end
    assign last_of_run = (idx_reg + 2'd1 == head.cnt);
    assign grp_done = pop && !empty && last_of_run;
    assign rd = grp_done;

    // Store groups that carry results only
    always_ff @(posedge clk)
    begin
        if (wr && grp.cnt != 2'd0)
            q_reg[wp_reg] <= grp;
    end

    // Advance pointers and byte index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            idx_reg <= 2'd0;
        end
        else
        begin
            if (wr && grp.cnt != 2'd0)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QAW+1)'(wr && grp.cnt != 2'd0) - (QAW+1)'(rd);
            if (grp_done)
                idx_reg <= 2'd0;
            else if (pop && !empty)
                idx_reg <= idx_reg + 2'd1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QAW+1)'(QDEPTH))
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> idx_reg == 2'd0)
        else $error("byte index set on empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> head.cnt != 2'd0)
        else $error("empty group in queue");
endmodule

// File: rtl/utf8_to_cp1251_stream.sv
`timescale 1ns / 1ps
// Each input beat's result bytes are registered as one group in a four-group queue.
// Throughput: one input beat per cycle while full is low; each gives zero to three
// output beats, drained one per cycle on pop, so full rises when output lags.
// Reset: rst_n clears held bytes and empties the queue asynchronously.
module utf8_to_cp1251_stream (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       end_of_stream,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last_of_run
);
    import u2c_pkg::*;

    grp_t grp;
    logic take;

    assign take = push && !full;

    u2c_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take),
        .in_byte(in_byte), .end_of_stream(end_of_stream), .grp(grp)
    );

    u2c_back u_back (
        .clk(clk), .rst_n(rst_n), .wr(take), .grp(grp), .q_full(full),
        .empty(empty), .pop(pop), .out_byte(out_byte), .last_of_run(last_of_run)
    );
endmodule
